// ----- hw/rtl/tffs_pkg.sv -----
package tffs_pkg;

    // Port field widths
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned INDEX_W     = 7;
    localparam int unsigned COMMAND_W   = 2;
    localparam int unsigned ACC_W       = 24;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    // Internal datapath widths
    localparam int unsigned LAP_RAW_W = 20;  // six-neighbor sum minus six times centre
    localparam int unsigned LAP_MUL_W = 37;  // times inverse squared spacing
    localparam int unsigned LAP_W     = 29;  // Laplacian, Q.12
    localparam int unsigned PROD2_W   = 32;  // product of two samples
    localparam int unsigned PROD3_W   = 48;  // product of three samples
    localparam int unsigned P16_W     = 27;  // P in Q.16
    localparam int unsigned DP16_W    = 24;  // dP in Q.16
    localparam int unsigned PSQ_W     = 54;  // P16 squared
    localparam int unsigned PD_W      = 51;  // P16 * dP16
    localparam int unsigned P2_W      = 35;  // P^2 in Q.16
    localparam int unsigned PM_LO_W   = 43;
    localparam int unsigned PM_HI_W   = 41;
    localparam int unsigned PK_LO_W   = 34;
    localparam int unsigned PK_HI_W   = 33;
    localparam int unsigned KSUM_W    = 51;
    localparam int unsigned NUM_W     = 64;  // mu * P16 * dP16
    localparam int unsigned MAG1_W    = 63;  // dividend of the first division
    localparam int unsigned DEN_W     = 43;  // 1 + kappa*P^2 in Q.16
    localparam int unsigned Q1_W      = 47;
    localparam int unsigned MAG2_W    = 52;  // dividend of the second division
    localparam int unsigned Q2_W      = 36;
    localparam int unsigned FORCE_W   = 37;
    localparam int unsigned ACC_WIDE_W = 38;

    // Split points of the wide products
    localparam int unsigned PM_SPLIT = 26;
    localparam int unsigned KP_SPLIT = 18;

    // Q.24 to Q.12 alignment before the second division (times 16)
    localparam int unsigned Q_ALIGN_SHIFT = 4;

    // 65536 (one in Q.16) pre-shifted by 8, plus the rounding half of the shift
    localparam logic [KSUM_W-1:0] DEN_BIAS = KSUM_W'(25'd16777344);

    // Points this close to an x or y edge get a zero result
    localparam int unsigned BORDER = 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 24'sh800000;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_INV_SPACING_SQ  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MU_STRENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SATURATION_GAIN = 2'd2;

    localparam logic [CFG_W-1:0]        INV_SPACING_SQ_RESET  = 16'd2581;
    localparam logic signed [CFG_W-1:0] MU_STRENGTH_RESET     = -16'sd12800;
    localparam logic [CFG_W-1:0]        SATURATION_GAIN_RESET = 16'd12800;

    // Component selector codes
    localparam logic [COMMAND_W-1:0] CMD_COMP0 = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_COMP1 = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_COMP2 = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t              neighbor_x_plus;
        sample_t              neighbor_x_minus;
        sample_t              neighbor_y_plus;
        sample_t              neighbor_y_minus;
        sample_t              neighbor_z_plus;
        sample_t              neighbor_z_minus;
        sample_t              field_one;
        sample_t              field_two;
        sample_t              field_three;
        logic [COMMAND_W-1:0] command;
        logic [INDEX_W-1:0]   column_x;
        logic [INDEX_W-1:0]   row_y;
    } point_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acceleration;
        logic                    saturated;
    } result_t;

    // Per-item data that rides along the dividers
    typedef struct packed {
        logic                    negative;
        logic                    at_border;
        logic signed [LAP_W-1:0] lap;
    } side_t;

endpackage

// ----- hw/rtl/tffs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// The dividend must be below den * 2^QUO_W; den must be nonzero.
module tffs_div
#(
    parameter int unsigned NUM_W  = 63,
    parameter int unsigned QUO_W  = 47,
    parameter int unsigned DEN_W  = 43,
    parameter int unsigned SIDE_W = 31
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              op_valid,
    input  logic [NUM_W-1:0]  op_num,
    input  logic [DEN_W-1:0]  op_den,
    input  logic [SIDE_W-1:0] op_tag,
    output logic              res_valid,
    output logic [QUO_W-1:0]  res_quo,
    output logic [DEN_W-1:0]  res_den,
    output logic [SIDE_W-1:0] res_tag
);

    logic              vld_in  [QUO_W];
    logic [DEN_W-1:0]  rem_in  [QUO_W];
    logic [QUO_W-1:0]  sh_in   [QUO_W];
    logic [DEN_W-1:0]  den_in  [QUO_W];
    logic [SIDE_W-1:0] tag_in  [QUO_W];

    logic              vld_reg [QUO_W];
    logic [DEN_W-1:0]  rem_reg [QUO_W];
    logic [QUO_W-1:0]  sh_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg [QUO_W];
    logic [SIDE_W-1:0] tag_reg [QUO_W];

    // Top dividend bits start as the partial remainder; the rest shift in.
    assign vld_in[0] = op_valid;
    assign rem_in[0] = DEN_W'(op_num[NUM_W-1:QUO_W]);
    assign sh_in[0]  = op_num[QUO_W-1:0];
    assign den_in[0] = op_den;
    assign tag_in[0] = op_tag;

    for (genvar k = 1; k < QUO_W; k++)
    begin : g_link
        assign vld_in[k] = vld_reg[k-1];
        assign rem_in[k] = rem_reg[k-1];
        assign sh_in[k]  = sh_reg[k-1];
        assign den_in[k] = den_reg[k-1];
        assign tag_in[k] = tag_reg[k-1];
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W+1:0] diff;
        logic             qbit;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_in[k], sh_in[k][QUO_W-1]};
            diff     = {1'b0, trial} - {2'b00, den_in[k]};
            qbit     = !diff[DEN_W+1];
            rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                sh_reg[k]  <= {sh_in[k][QUO_W-2:0], qbit};
                den_reg[k] <= den_in[k];
                tag_reg[k] <= tag_in[k];
            end
        end
    end

    assign res_valid = vld_reg[QUO_W-1];
    assign res_quo   = sh_reg[QUO_W-1];
    assign res_den   = den_reg[QUO_W-1];
    assign res_tag   = tag_reg[QUO_W-1];

endmodule

// ----- hw/rtl/triple_field_force_stencil_top.sv -----
// Triple-field force stencil. Each point item carries the six face neighbors of the
// selected component, the three centre samples and the point's x/y indices; the block
// returns one result item per point: the seven-point Laplacian scaled by the inverse
// squared spacing, minus mu*P*dP/(1+kappa*P^2)^2, saturated to Q11.12 with a flag,
// and zero for points within two cells of an x or y edge. A new point is taken every
// cycle while point_ready is high. Most of the pipeline depth is the two restoring
// dividers for the rounded divisions by 1+kappa*P^2, which retire one quotient bit
// per stage (47 stages, then 36 stages), with the multiply, rounding and output
// stages around them. When the result item is not taken, the output register and a
// one-entry skid stage absorb the item in flight and point_ready drops until the skid
// drains. Registers are written through the cfg port (index 0 inverse squared
// spacing, 1 mu, 2 kappa; index 3 is ignored) and must only change while the
// pipeline is empty.
module triple_field_force_stencil_top
    import tffs_pkg::*;
#(
    parameter int unsigned GRID_SIZE = 128
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   point_valid,
    output logic                   point_ready,
    input  point_t                 point,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result
);

    localparam int unsigned BORDER_HI = GRID_SIZE - BORDER;
    localparam int unsigned SIDE_W    = $bits(side_t);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]        isq_reg;
    logic signed [CFG_W-1:0] mu_reg;
    logic [CFG_W-1:0]        kappa_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isq_reg   <= INV_SPACING_SQ_RESET;
            mu_reg    <= MU_STRENGTH_RESET;
            kappa_reg <= SATURATION_GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INV_SPACING_SQ:  isq_reg   <= cfg_data;
                REG_MU_STRENGTH:     mu_reg    <= signed'(cfg_data);
                REG_SATURATION_GAIN: kappa_reg <= cfg_data;
                default: ;  // index beyond the register list: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: the whole pipeline moves unless the skid stage holds
    // an item. The skid flag is registered, so point_ready never depends
    // combinationally on result_ready.
    // ------------------------------------------------------------------
    logic en;
    logic skid_vld_reg;

    assign en          = !skid_vld_reg;
    assign point_ready = en;

    // ------------------------------------------------------------------
    // Stage 1: select component, raw Laplacian, two-sample products
    // ------------------------------------------------------------------
    sample_t                     centre;
    sample_t                     other_a;
    sample_t                     other_b;
    logic signed [LAP_RAW_W-1:0] c_wide;
    logic signed [LAP_RAW_W-1:0] nb_sum;
    logic signed [LAP_RAW_W-1:0] lap_raw_next;
    logic signed [PROD2_W-1:0]   f01_next;
    logic signed [PROD2_W-1:0]   dp24_next;
    logic                        border_next;

    always_comb
    begin
        unique case (point.command)
            CMD_COMP0:
            begin
                centre  = point.field_one;
                other_a = point.field_two;
                other_b = point.field_three;
            end
            CMD_COMP1:
            begin
                centre  = point.field_two;
                other_a = point.field_one;
                other_b = point.field_three;
            end
            default:  // component 2, and the unused selector code acts the same
            begin
                centre  = point.field_three;
                other_a = point.field_one;
                other_b = point.field_two;
            end
        endcase
    end

    always_comb
    begin
        c_wide = LAP_RAW_W'(centre);
        nb_sum = LAP_RAW_W'(point.neighbor_x_plus) + LAP_RAW_W'(point.neighbor_x_minus)
               + LAP_RAW_W'(point.neighbor_y_plus) + LAP_RAW_W'(point.neighbor_y_minus)
               + LAP_RAW_W'(point.neighbor_z_plus) + LAP_RAW_W'(point.neighbor_z_minus);
        // subtract six times the centre as 4x + 2x
        lap_raw_next = nb_sum - ((c_wide <<< 2) + (c_wide <<< 1));
        f01_next     = point.field_one * point.field_two;
        dp24_next    = other_a * other_b;
        border_next  = (32'(point.column_x) < BORDER) || (32'(point.column_x) >= BORDER_HI)
                    || (32'(point.row_y) < BORDER) || (32'(point.row_y) >= BORDER_HI);
    end

    logic                        s1_vld_reg;
    logic signed [LAP_RAW_W-1:0] s1_lap_raw_reg;
    logic signed [PROD2_W-1:0]   s1_f01_reg;
    logic signed [PROD2_W-1:0]   s1_dp24_reg;
    sample_t                     s1_f2_reg;
    logic                        s1_border_reg;

    // ------------------------------------------------------------------
    // Stage 2: scale Laplacian, three-sample product, round dP
    // ------------------------------------------------------------------
    logic signed [LAP_MUL_W-1:0] lap_mul_next;
    logic signed [PROD3_W-1:0]   p45_next;
    logic signed [PROD2_W:0]     dp_rnd;
    logic signed [DP16_W-1:0]    dp16_next;

    always_comb
    begin
        lap_mul_next = s1_lap_raw_reg * signed'({1'b0, isq_reg});
        p45_next     = s1_f01_reg * s1_f2_reg;
        dp_rnd       = (PROD2_W+1)'(s1_dp24_reg) + (PROD2_W+1)'(128);
        dp16_next    = dp_rnd[PROD2_W-1:8];
    end

    logic                        s2_vld_reg;
    logic signed [LAP_MUL_W-1:0] s2_lap_mul_reg;
    logic signed [PROD3_W-1:0]   s2_p45_reg;
    logic signed [DP16_W-1:0]    s2_dp16_reg;
    logic                        s2_border_reg;

    // ------------------------------------------------------------------
    // Stage 3: round P to Q.16 and the Laplacian to Q.12
    // ------------------------------------------------------------------
    logic signed [PROD3_W:0]   p_rnd;
    logic signed [P16_W-1:0]   p16_next;
    logic signed [LAP_MUL_W:0] l_rnd;
    logic signed [LAP_W-1:0]   lap_next;

    always_comb
    begin
        p_rnd    = (PROD3_W+1)'(s2_p45_reg) + (PROD3_W+1)'(524288);
        p16_next = p_rnd[P16_W+19:20];
        l_rnd    = (LAP_MUL_W+1)'(s2_lap_mul_reg) + (LAP_MUL_W+1)'(128);
        lap_next = l_rnd[LAP_W+7:8];
    end

    logic                     s3_vld_reg;
    logic signed [P16_W-1:0]  s3_p16_reg;
    logic signed [DP16_W-1:0] s3_dp16_reg;
    logic signed [LAP_W-1:0]  s3_lap_reg;
    logic                     s3_border_reg;

    // ------------------------------------------------------------------
    // Stage 4: P squared and P*dP
    // ------------------------------------------------------------------
    logic signed [PSQ_W-1:0] psq_next;
    logic signed [PD_W-1:0]  pd_next;

    always_comb
    begin
        psq_next = s3_p16_reg * s3_p16_reg;
        pd_next  = s3_p16_reg * s3_dp16_reg;
    end

    logic                    s4_vld_reg;
    logic [PSQ_W-1:0]        s4_psq_reg;   // never negative
    logic signed [PD_W-1:0]  s4_pd_reg;
    logic signed [LAP_W-1:0] s4_lap_reg;
    logic                    s4_border_reg;

    // ------------------------------------------------------------------
    // Stage 5: round P^2, mu*P*dP as two partial products
    // ------------------------------------------------------------------
    logic [PSQ_W:0]            sq_rnd;
    logic [P2_W-1:0]           p2_next;
    logic signed [PM_LO_W-1:0] pm_lo_next;
    logic signed [PM_HI_W-1:0] pm_hi_next;

    always_comb
    begin
        sq_rnd     = {1'b0, s4_psq_reg} + (PSQ_W+1)'(32768);
        p2_next    = sq_rnd[P2_W+15:16];
        pm_lo_next = signed'({1'b0, s4_pd_reg[PM_SPLIT-1:0]}) * mu_reg;
        pm_hi_next = signed'(s4_pd_reg[PD_W-1:PM_SPLIT]) * mu_reg;
    end

    logic                      s5_vld_reg;
    logic [P2_W-1:0]           s5_p2_reg;
    logic signed [PM_LO_W-1:0] s5_pm_lo_reg;
    logic signed [PM_HI_W-1:0] s5_pm_hi_reg;
    logic signed [LAP_W-1:0]   s5_lap_reg;
    logic                      s5_border_reg;

    // ------------------------------------------------------------------
    // Stage 6: combine numerator, kappa*P^2 as two partial products
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] num_next;
    logic [PK_LO_W-1:0]      pk_lo_next;
    logic [PK_HI_W-1:0]      pk_hi_next;

    always_comb
    begin
        num_next   = (NUM_W'(s5_pm_hi_reg) <<< PM_SPLIT) + NUM_W'(s5_pm_lo_reg);
        pk_lo_next = s5_p2_reg[KP_SPLIT-1:0] * kappa_reg;
        pk_hi_next = s5_p2_reg[P2_W-1:KP_SPLIT] * kappa_reg;
    end

    logic                    s6_vld_reg;
    logic signed [NUM_W-1:0] s6_num_reg;
    logic [PK_LO_W-1:0]      s6_pk_lo_reg;
    logic [PK_HI_W-1:0]      s6_pk_hi_reg;
    logic signed [LAP_W-1:0] s6_lap_reg;
    logic                    s6_border_reg;

    // ------------------------------------------------------------------
    // Stage 7: denominator D = 1 + rnd(kappa*P^2), numerator magnitude
    // ------------------------------------------------------------------
    logic [KSUM_W-1:0]       ksum;
    logic [DEN_W-1:0]        den_next;
    logic signed [NUM_W-1:0] num_neg;
    logic                    neg_next;
    logic [MAG1_W-1:0]       mag_next;

    always_comb
    begin
        ksum     = {s6_pk_hi_reg, KP_SPLIT'(0)} + KSUM_W'(s6_pk_lo_reg) + DEN_BIAS;
        den_next = ksum[DEN_W+7:8];
        num_neg  = -s6_num_reg;
        neg_next = s6_num_reg[NUM_W-1];
        mag_next = neg_next ? num_neg[MAG1_W-1:0] : s6_num_reg[MAG1_W-1:0];
    end

    logic                    s7_vld_reg;
    logic [DEN_W-1:0]        s7_den_reg;
    logic                    s7_neg_reg;
    logic [MAG1_W-1:0]       s7_mag_reg;
    logic signed [LAP_W-1:0] s7_lap_reg;
    logic                    s7_border_reg;

    // ------------------------------------------------------------------
    // Stage 8: add half of D for round-half-away division
    // ------------------------------------------------------------------
    logic [MAG1_W-1:0] m1_next;
    side_t             tag8_next;

    always_comb
    begin
        m1_next             = s7_mag_reg + MAG1_W'(s7_den_reg >> 1);
        tag8_next.negative  = s7_neg_reg;
        tag8_next.at_border = s7_border_reg;
        tag8_next.lap       = s7_lap_reg;
    end

    logic              s8_vld_reg;
    logic [MAG1_W-1:0] s8_m1_reg;
    logic [DEN_W-1:0]  s8_den_reg;
    side_t             s8_tag_reg;

    // ------------------------------------------------------------------
    // First division: |q1| = round(|mu*P*dP| / D), Q.24
    // ------------------------------------------------------------------
    logic             d1_vld;
    logic [Q1_W-1:0]  d1_quo;
    logic [DEN_W-1:0] d1_den;
    side_t            d1_tag;

    tffs_div #(
        .NUM_W  (MAG1_W),
        .QUO_W  (Q1_W),
        .DEN_W  (DEN_W),
        .SIDE_W (SIDE_W)
    ) u_div_q1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .op_valid  (s8_vld_reg),
        .op_num    (s8_m1_reg),
        .op_den    (s8_den_reg),
        .op_tag    (s8_tag_reg),
        .res_valid (d1_vld),
        .res_quo   (d1_quo),
        .res_den   (d1_den),
        .res_tag   (d1_tag)
    );

    // ------------------------------------------------------------------
    // Stage 9: align q1 to Q.12 scale (times 16) and add half of D again
    // ------------------------------------------------------------------
    logic [MAG2_W-1:0] m2_next;

    assign m2_next = MAG2_W'({d1_quo, Q_ALIGN_SHIFT'(0)}) + MAG2_W'(d1_den >> 1);

    logic              s9_vld_reg;
    logic [MAG2_W-1:0] s9_m2_reg;
    logic [DEN_W-1:0]  s9_den_reg;
    side_t             s9_tag_reg;

    // ------------------------------------------------------------------
    // Second division: |F| = round(|q1|*16 / D), Q.12
    // ------------------------------------------------------------------
    logic             d2_vld;
    logic [Q2_W-1:0]  d2_quo;
    logic [DEN_W-1:0] d2_den;
    side_t            d2_tag;

    tffs_div #(
        .NUM_W  (MAG2_W),
        .QUO_W  (Q2_W),
        .DEN_W  (DEN_W),
        .SIDE_W (SIDE_W)
    ) u_div_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .op_valid  (s9_vld_reg),
        .op_num    (s9_m2_reg),
        .op_den    (s9_den_reg),
        .op_tag    (s9_tag_reg),
        .res_valid (d2_vld),
        .res_quo   (d2_quo),
        .res_den   (d2_den),
        .res_tag   (d2_tag)
    );

    // ------------------------------------------------------------------
    // Stage 10: restore the sign of the potential force
    // ------------------------------------------------------------------
    logic signed [FORCE_W-1:0] force_mag;
    logic signed [FORCE_W-1:0] pot_force_next;

    always_comb
    begin
        force_mag      = signed'({1'b0, d2_quo});
        pot_force_next = d2_tag.negative ? -force_mag : force_mag;
    end

    logic                      s10_vld_reg;
    logic signed [FORCE_W-1:0] s10_pot_force_reg;
    side_t                     s10_tag_reg;

    // ------------------------------------------------------------------
    // Stage 11: subtract, saturate, zero the border points
    // ------------------------------------------------------------------
    logic signed [ACC_WIDE_W-1:0] acc_wide;
    result_t                      res_next;

    always_comb
    begin
        acc_wide = ACC_WIDE_W'(s10_tag_reg.lap) - ACC_WIDE_W'(s10_pot_force_reg);
        if (s10_tag_reg.at_border)
        begin
            res_next.acceleration = '0;
            res_next.saturated    = 1'b0;
        end
        else if (acc_wide > ACC_WIDE_W'(ACC_MAX))
        begin
            res_next.acceleration = ACC_MAX;
            res_next.saturated    = 1'b1;
        end
        else if (acc_wide < ACC_WIDE_W'(ACC_MIN))
        begin
            res_next.acceleration = ACC_MIN;
            res_next.saturated    = 1'b1;
        end
        else
        begin
            res_next.acceleration = acc_wide[ACC_W-1:0];
            res_next.saturated    = 1'b0;
        end
    end

    logic    s11_vld_reg;
    result_t s11_res_reg;

    // ------------------------------------------------------------------
    // Pipeline registers: valid bits reset, payload only loads on advance
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= point_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= d1_vld;
            s10_vld_reg <= d2_vld;
            s11_vld_reg <= s10_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_lap_raw_reg    <= lap_raw_next;
            s1_f01_reg        <= f01_next;
            s1_dp24_reg       <= dp24_next;
            s1_f2_reg         <= point.field_three;
            s1_border_reg     <= border_next;

            s2_lap_mul_reg    <= lap_mul_next;
            s2_p45_reg        <= p45_next;
            s2_dp16_reg       <= dp16_next;
            s2_border_reg     <= s1_border_reg;

            s3_p16_reg        <= p16_next;
            s3_dp16_reg       <= s2_dp16_reg;
            s3_lap_reg        <= lap_next;
            s3_border_reg     <= s2_border_reg;

            s4_psq_reg        <= psq_next;
            s4_pd_reg         <= pd_next;
            s4_lap_reg        <= s3_lap_reg;
            s4_border_reg     <= s3_border_reg;

            s5_p2_reg         <= p2_next;
            s5_pm_lo_reg      <= pm_lo_next;
            s5_pm_hi_reg      <= pm_hi_next;
            s5_lap_reg        <= s4_lap_reg;
            s5_border_reg     <= s4_border_reg;

            s6_num_reg        <= num_next;
            s6_pk_lo_reg      <= pk_lo_next;
            s6_pk_hi_reg      <= pk_hi_next;
            s6_lap_reg        <= s5_lap_reg;
            s6_border_reg     <= s5_border_reg;

            s7_den_reg        <= den_next;
            s7_neg_reg        <= neg_next;
            s7_mag_reg        <= mag_next;
            s7_lap_reg        <= s6_lap_reg;
            s7_border_reg     <= s6_border_reg;

            s8_m1_reg         <= m1_next;
            s8_den_reg        <= s7_den_reg;
            s8_tag_reg        <= tag8_next;

            s9_m2_reg         <= m2_next;
            s9_den_reg        <= d1_den;
            s9_tag_reg        <= d1_tag;

            s10_pot_force_reg <= pot_force_next;
            s10_tag_reg       <= d2_tag;

            s11_res_reg       <= res_next;
        end
    end

    // D leaves the second divider unused: the quotient is all that is needed.
    logic unused_den;
    assign unused_den = ^d2_den;

    // ------------------------------------------------------------------
    // Output register plus one-entry skid stage
    // ------------------------------------------------------------------
    logic    push;
    logic    out_free;
    logic    out_vld_reg;
    logic    out_vld_next;
    logic    skid_vld_next;
    logic    out_load_skid;
    logic    out_load_pipe;
    logic    skid_load;
    result_t out_reg;
    result_t skid_reg;

    assign push     = en && s11_vld_reg;
    assign out_free = !out_vld_reg || result_ready;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_load_skid = 1'b0;
        out_load_pipe = 1'b0;
        skid_load     = 1'b0;
        if (out_free)
        begin
            if (skid_vld_reg)
            begin
                // drain the skid first; the pipeline is held meanwhile
                out_vld_next  = 1'b1;
                out_load_skid = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next  = push;
                out_load_pipe = push;
            end
        end
        else if (push)
        begin
            // output stalled: park the arriving item
            skid_vld_next = 1'b1;
            skid_load     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_skid)
        begin
            out_reg <= skid_reg;
        end
        else if (out_load_pipe)
        begin
            out_reg <= s11_res_reg;
        end
        if (skid_load)
        begin
            skid_reg <= s11_res_reg;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

// ----- hw/rtl/tffs_check.sv -----
// Port-level checks for the force stencil.
module tffs_check
    import tffs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    point_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // Hold a stalled result item.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    // A clipped value sits exactly on a range limit.
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            result.acceleration == ACC_MAX || result.acceleration == ACC_MIN)
        else $error("saturated flag without a limit value");

    // Input back-pressure only follows an output stall.
    a_ready_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> $past(result_valid && !result_ready))
        else $error("point_ready low without an output stall");

endmodule

bind triple_field_force_stencil_top tffs_check u_tffs_check (.*);
